/* rtl/core/smjt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package smjt_pkg;

   localparam int JOINTS      = 6;
   localparam int TANH_POINTS = 256;

   // joint select field is 3 bits wide; array index keeps only what JOINTS needs
   localparam int JOINT_W     = 3;
   localparam int JOINT_IDX_W = (JOINTS > 1) ?
                                (($clog2(JOINTS) > JOINT_W) ? JOINT_W : $clog2(JOINTS)) : 1;
   localparam int TANH_IDX_W  = $clog2(TANH_POINTS + 1);

   typedef logic [1:0]         opcode_type;
   typedef logic [JOINT_W-1:0] joint_type;
   typedef logic signed [31:0] angle_type;
   typedef logic [31:0]        word_type;
   typedef logic [1:0]         csr_index_type;

   localparam opcode_type OP_STEP  = 2'd0;
   localparam opcode_type OP_START = 2'd1;
   localparam opcode_type OP_STOP  = 2'd2;

   localparam csr_index_type CSR_LAMBDA   = 2'd0;
   localparam csr_index_type CSR_REACH    = 2'd1;
   localparam csr_index_type CSR_INV_BND  = 2'd2;

   localparam word_type LAMBDA_RESET  = 32'd65536;
   localparam word_type REACH_RESET   = 32'd655360;
   localparam word_type INV_BND_RESET = 32'd65536;

   // 1e-6 s in Q8.24
   localparam word_type DT_MIN_RAW = 32'd16;

   localparam logic [16:0] ONE_Q16 = 17'd65536;

   typedef logic [16:0] tanh_tbl_type [0:TANH_POINTS];

   // restoring long division, only used while building the constant table
   function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] q;
      logic [64:0] r;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[63:0], n[b]};
         if (r >= {1'b0, d}) begin
            r    = r - {1'b0, d};
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // tanh nodes in Q1.16 from exp(-2x) series, evaluated at elaboration
   function automatic tanh_tbl_type build_tanh();
      tanh_tbl_type t;
      logic [63:0]  one_q30;
      logic [63:0]  z;
      logic [63:0]  term;
      logic [63:0]  sum;
      logic [63:0]  num;
      logic [63:0]  den;
      one_q30 = 64'd1 << 30;
      for (int i = 0; i <= TANH_POINTS; i++) begin
         z    = udiv64(64'(i) << 30, 64'(2 * TANH_POINTS));
         term = one_q30;
         sum  = one_q30;
         for (int k = 1; k <= 12; k++) begin
            term = udiv64((term * z) >> 30, 64'(k));
            if ((k & 1) == 1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         for (int k = 0; k < 4; k++) begin
            sum = (sum * sum) >> 30;
         end
         num  = (one_q30 - sum) << 16;
         den  = one_q30 + sum;
         t[i] = 17'(udiv64(num + (den >> 1), den));
      end
      t[TANH_POINTS] = ONE_Q16;
      return t;
   endfunction

   localparam tanh_tbl_type TANH_NODE = build_tanh();

endpackage

`default_nettype wire

/* rtl/core/smjt_ifs.sv */
`timescale 1ns / 1ps
`default_nettype none

interface smjt_req_if;
   import smjt_pkg::*;
   logic       valid;
   logic       ready;
   opcode_type opcode;
   joint_type  joint_index;
   angle_type  target_angle;
   word_type   step_time;
   modport source (output valid, opcode, joint_index, target_angle, step_time, input ready);
   modport sink   (input valid, opcode, joint_index, target_angle, step_time, output ready);
endinterface

interface smjt_rsp_if;
   import smjt_pkg::*;
   logic      valid;
   logic      ready;
   joint_type joint_index_res;
   angle_type commanded_angle;
   modport source (output valid, joint_index_res, commanded_angle, input ready);
   modport sink   (input valid, joint_index_res, commanded_angle, output ready);
endinterface

interface smjt_csr_if;
   import smjt_pkg::*;
   logic          valid;
   logic          ready;
   csr_index_type index;
   word_type      data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/core/sliding_mode_joint_tracker_top.sv */
// Sliding-mode joint tracker, fixed point, up to JOINTS joints.
// req_chan: one word per command. Start seeds a joint's command angle and
//   enables the block; stop disables it; step pulls the joint toward a target.
// rsp_chan: one word per accepted step (joint index and new command angle).
//   Start, stop, ignored steps (disabled, dt <= 1e-6 s, bad joint) give none.
// csr_chan: register writes (0 lambda_gain, 1 reach_gain, 2 inv_boundary),
//   always ready; write only while no step is in flight.
// Timing: start/stop complete on acceptance. A step holds the block through
//   states ERR, MLE, LE, SURF, MX, XCHK, MPOS, TA, TB, MT, Y, MR, VEL, MD, CMD,
//   skipping MPOS to Y when |s|*inv_boundary reaches 4.0; the result word is
//   registered on leaving CMD. A single shared 33x33 multiplier is used six
//   times per step (four on the short path), with each product registered.
// req_chan.ready is low while a step runs. A finished word waits in the output
//   register; a new item is taken meanwhile, and a following step holds in its
//   final stage until the waiting word is taken.
// Reset (synchronous, active high) zeroes all joint state, disables the block
//   and restores the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module sliding_mode_joint_tracker_top (
   input  wire logic   clock,
   input  wire logic   reset,
   smjt_req_if.sink    req_chan,
   smjt_rsp_if.source  rsp_chan,
   smjt_csr_if.sink    csr_chan
);
   import smjt_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_ERR  = 4'd1;
   localparam logic [3:0] S_MLE  = 4'd2;
   localparam logic [3:0] S_LE   = 4'd3;
   localparam logic [3:0] S_SURF = 4'd4;
   localparam logic [3:0] S_MX   = 4'd5;
   localparam logic [3:0] S_XCHK = 4'd6;
   localparam logic [3:0] S_MPOS = 4'd7;
   localparam logic [3:0] S_TA   = 4'd8;
   localparam logic [3:0] S_TB   = 4'd9;
   localparam logic [3:0] S_MT   = 4'd10;
   localparam logic [3:0] S_Y    = 4'd11;
   localparam logic [3:0] S_MR   = 4'd12;
   localparam logic [3:0] S_VEL  = 4'd13;
   localparam logic [3:0] S_MD   = 4'd14;
   localparam logic [3:0] S_CMD  = 4'd15;

   localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
   localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

   function automatic logic signed [65:0] shr_tz(input logic signed [65:0] v,
                                                 input int unsigned sh);
      logic [65:0] mag;
      mag = v[65] ? 66'(-v) : 66'(v);
      mag = mag >> sh;
      return v[65] ? -$signed(mag) : $signed(mag);
   endfunction

   function automatic angle_type sat32(input logic signed [65:0] v);
      angle_type r;
      if (v > SAT_MAX) begin
         r = 32'sh7FFFFFFF;
      end else if (v < SAT_MIN) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   logic [3:0]             state_ff, state_in;
   logic                   enabled_ff, enabled_in;
   word_type               lambda_ff, lambda_in;
   word_type               reach_ff, reach_in;
   word_type               inv_ff, inv_in;
   angle_type              cmd_ff [JOINTS], cmd_in [JOINTS];
   angle_type              pv_ff [JOINTS], pv_in [JOINTS];

   joint_type              joint_ff, joint_in;
   angle_type              target_ff, target_in;
   word_type               dt_ff, dt_in;
   angle_type              err_ff, err_in;
   angle_type              le_ff, le_in;
   angle_type              s_ff, s_in;
   angle_type              vel_ff, vel_in;
   logic [17:0]            x_ff, x_in;
   logic [17:0]            frac_ff, frac_in;
   logic [TANH_IDX_W-1:0]  tidx_ff, tidx_in;
   logic [16:0]            node_a_ff, node_a_in;
   logic signed [17:0]     diff_ff, diff_in;
   logic signed [17:0]     y_ff, y_in;
   logic signed [65:0]     prod_ff, prod_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   joint_type              rsp_joint_ff, rsp_joint_in;
   angle_type              rsp_cmd_ff, rsp_cmd_in;

   logic [JOINT_IDX_W-1:0] jx;
   logic signed [32:0]     mul_a, mul_b;
   logic [31:0]            s_mag;
   logic [TANH_IDX_W-1:0]  tbl_addr;
   logic [16:0]            tbl_data;
   logic signed [65:0]     y_full;
   angle_type              cmd_new;
   logic                   req_fire;
   logic                   req_joint_ok;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.joint_index_res = rsp_joint_ff;
   assign rsp_chan.commanded_angle = rsp_cmd_ff;

   assign req_fire     = req_chan.valid && req_chan.ready;
   assign req_joint_ok = ({29'd0, req_chan.joint_index} < 32'(JOINTS));
   assign jx           = joint_ff[JOINT_IDX_W-1:0];
   assign s_mag        = s_ff[31] ? (~s_ff + 32'd1) : s_ff;

   // single table read port: first node at S_TA, its neighbor at S_TB
   assign tbl_addr = (state_ff == S_TA) ? prod_ff[18 +: TANH_IDX_W] : tidx_ff + 1'b1;
   assign tbl_data = TANH_NODE[tbl_addr];

   assign y_full  = $signed({49'd0, node_a_ff}) + shr_tz(prod_ff, 18);
   assign cmd_new = sat32($signed({{34{cmd_ff[jx][31]}}, cmd_ff[jx]}) + shr_tz(prod_ff, 24));

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_MLE: begin
            mul_a = $signed({err_ff[31], err_ff});
            mul_b = $signed({1'b0, lambda_ff});
         end
         S_MX: begin
            mul_a = $signed({1'b0, s_mag});
            mul_b = $signed({1'b0, inv_ff});
         end
         S_MPOS: begin
            mul_a = $signed({15'd0, x_ff});
            mul_b = 33'(TANH_POINTS);
         end
         S_MT: begin
            mul_a = $signed({{15{diff_ff[17]}}, diff_ff});
            mul_b = $signed({15'd0, frac_ff});
         end
         S_MR: begin
            mul_a = $signed({1'b0, reach_ff});
            mul_b = $signed({{15{y_ff[17]}}, y_ff});
         end
         S_MD: begin
            mul_a = $signed({vel_ff[31], vel_ff});
            mul_b = $signed({1'b0, dt_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      enabled_in   = enabled_ff;
      lambda_in    = lambda_ff;
      reach_in     = reach_ff;
      inv_in       = inv_ff;
      cmd_in       = cmd_ff;
      pv_in        = pv_ff;
      joint_in     = joint_ff;
      target_in    = target_ff;
      dt_in        = dt_ff;
      err_in       = err_ff;
      le_in        = le_ff;
      s_in         = s_ff;
      vel_in       = vel_ff;
      x_in         = x_ff;
      frac_in      = frac_ff;
      tidx_in      = tidx_ff;
      node_a_in    = node_a_ff;
      diff_in      = diff_ff;
      y_in         = y_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_joint_in = rsp_joint_ff;
      rsp_cmd_in   = rsp_cmd_ff;

      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_LAMBDA:  lambda_in = csr_chan.data;
            CSR_REACH:   reach_in  = csr_chan.data;
            CSR_INV_BND: inv_in    = csr_chan.data;
            default:     ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && req_joint_ok) begin
               joint_in  = req_chan.joint_index;
               target_in = req_chan.target_angle;
               dt_in     = req_chan.step_time;
               unique case (req_chan.opcode)
                  OP_START: begin
                     cmd_in[req_chan.joint_index[JOINT_IDX_W-1:0]] = req_chan.target_angle;
                     enabled_in = 1'b1;
                  end
                  OP_STOP: enabled_in = 1'b0;
                  OP_STEP: begin
                     if (enabled_ff && (req_chan.step_time > DT_MIN_RAW)) begin
                        state_in = S_ERR;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_ERR: begin
            err_in   = sat32($signed({{34{target_ff[31]}}, target_ff})
                             - $signed({{34{cmd_ff[jx][31]}}, cmd_ff[jx]}));
            state_in = S_MLE;
         end
         S_MLE: begin
            prod_in  = 66'(mul_a) * 66'(mul_b);
            state_in = S_LE;
         end
         S_LE: begin
            le_in    = sat32(shr_tz(prod_ff, 16));
            state_in = S_SURF;
         end
         S_SURF: begin
            s_in     = sat32($signed({{34{le_ff[31]}}, le_ff})
                             - $signed({{34{pv_ff[jx][31]}}, pv_ff[jx]}));
            state_in = S_MX;
         end
         S_MX: begin
            prod_in  = 66'(mul_a) * 66'(mul_b);
            state_in = S_XCHK;
         end
         S_XCHK: begin
            // tanh saturates at x >= 4.0 (Q16.16)
            if (prod_ff[65:34] != '0) begin
               y_in     = s_ff[31] ? -$signed({1'b0, ONE_Q16}) : $signed({1'b0, ONE_Q16});
               state_in = S_MR;
            end else begin
               x_in     = prod_ff[33:16];
               state_in = S_MPOS;
            end
         end
         S_MPOS: begin
            prod_in  = 66'(mul_a) * 66'(mul_b);
            state_in = S_TA;
         end
         S_TA: begin
            tidx_in   = prod_ff[18 +: TANH_IDX_W];
            frac_in   = prod_ff[17:0];
            node_a_in = tbl_data;
            state_in  = S_TB;
         end
         S_TB: begin
            diff_in  = $signed({1'b0, tbl_data}) - $signed({1'b0, node_a_ff});
            state_in = S_MT;
         end
         S_MT: begin
            prod_in  = 66'(mul_a) * 66'(mul_b);
            state_in = S_Y;
         end
         S_Y: begin
            y_in     = s_ff[31] ? -y_full[17:0] : y_full[17:0];
            state_in = S_MR;
         end
         S_MR: begin
            prod_in  = 66'(mul_a) * 66'(mul_b);
            state_in = S_VEL;
         end
         S_VEL: begin
            vel_in   = sat32(shr_tz(prod_ff, 16) + $signed({{34{le_ff[31]}}, le_ff}));
            state_in = S_MD;
         end
         S_MD: begin
            prod_in  = 66'(mul_a) * 66'(mul_b);
            state_in = S_CMD;
         end
         S_CMD: begin
            // hold here while the previous word is still waiting
            if (!rsp_valid_ff || rsp_chan.ready) begin
               cmd_in[jx]   = cmd_new;
               pv_in[jx]    = vel_ff;
               rsp_valid_in = 1'b1;
               rsp_joint_in = joint_ff;
               rsp_cmd_in   = cmd_new;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         enabled_ff   <= 1'b0;
         lambda_ff    <= LAMBDA_RESET;
         reach_ff     <= REACH_RESET;
         inv_ff       <= INV_BND_RESET;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j < JOINTS; j++) begin
            cmd_ff[j] <= '0;
            pv_ff[j]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         enabled_ff   <= enabled_in;
         lambda_ff    <= lambda_in;
         reach_ff     <= reach_in;
         inv_ff       <= inv_in;
         rsp_valid_ff <= rsp_valid_in;
         cmd_ff       <= cmd_in;
         pv_ff        <= pv_in;
      end
   end

   always_ff @(posedge clock) begin
      joint_ff     <= joint_in;
      target_ff    <= target_in;
      dt_ff        <= dt_in;
      err_ff       <= err_in;
      le_ff        <= le_in;
      s_ff         <= s_in;
      vel_ff       <= vel_in;
      x_ff         <= x_in;
      frac_ff      <= frac_in;
      tidx_ff      <= tidx_in;
      node_a_ff    <= node_a_in;
      diff_ff      <= diff_in;
      y_ff         <= y_in;
      prod_ff      <= prod_in;
      rsp_joint_ff <= rsp_joint_in;
      rsp_cmd_ff   <= rsp_cmd_in;
   end

endmodule

`default_nettype wire

/* verif/sliding_mode_joint_tracker_top_tb.sv */
`timescale 1ns / 1ps

module sliding_mode_joint_tracker_top_tb;
   import smjt_pkg::*;

   localparam opcode_type    OP_UNUSED    = 2'd3;
   localparam csr_index_type CSR_UNUSED   = 2'd3;
   localparam int            QUIET_CYCLES = 24;
   localparam int            CYCLE_LIMIT  = 400000;
   localparam int            REPORT_LIMIT = 10;
   localparam longint        Q16_MAX      = 64'sd2147483647;
   localparam longint        Q16_MIN      = -64'sd2147483648;
   // 4.0 in Q16.16; table segment index is x*N >> 18
   localparam longint        TANH_X_LIMIT = 262144;
   localparam int            TANH_SEG_SH  = 18;
   localparam word_type      DT_TEN_MS    = 32'd167772;
   localparam word_type      DT_ONE_S     = 32'h0100_0000;
   localparam word_type      WORD_MAX     = 32'hFFFF_FFFF;

   typedef struct packed {
      joint_type joint;
      angle_type angle;
   } joint_update_type;

   logic clock = 1'b0;
   logic reset;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   smjt_req_if req_bus ();
   smjt_rsp_if rsp_bus ();
   smjt_csr_if csr_bus ();

   sliding_mode_joint_tracker_top u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // tracker state as the block should hold it
   word_type         gain_lambda;
   word_type         gain_reach;
   word_type         gain_inv_bnd;
   angle_type        joint_cmd [JOINTS];
   angle_type        joint_speed [JOINTS];
   bit               tracking_on;
   int               tanh_lut [0:TANH_POINTS];
   joint_update_type pending_updates [$];

   int src_idle_pct;
   int rsp_idle_pct;
   int fail_count    = 0;
   int applied_items = 0;
   int cycle_count   = 0;

   function automatic void build_tanh_lut();
      longint unsigned one;
      longint unsigned z;
      longint unsigned term;
      longint unsigned acc;
      longint unsigned num;
      longint unsigned den;
      one = 64'd1 << 30;
      for (int i = 0; i <= TANH_POINTS; i++) begin
         z = i;
         z = (z << 30) / (2 * TANH_POINTS);
         term = one;
         acc  = one;
         // e^(-z) series in Q30
         for (int k = 1; k <= 12; k++) begin
            term = ((term * z) >> 30) / k;
            if ((k % 2) == 1) begin
               acc = acc - term;
            end else begin
               acc = acc + term;
            end
         end
         // raise to the 16th power: e^(-2x)
         repeat (4) acc = (acc * acc) >> 30;
         num = (one - acc) << 16;
         den = one + acc;
         tanh_lut[i] = int'((num + den / 2) / den);
      end
      tanh_lut[TANH_POINTS] = 65536;
   endfunction

   function automatic longint trunc_shift(longint v, int sh);
      longint unsigned mag;
      mag = (v < 0) ? -v : v;
      mag = mag >> sh;
      return (v < 0) ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic angle_type clamp_q16(longint v);
      if (v > Q16_MAX) return angle_type'(Q16_MAX);
      if (v < Q16_MIN) return angle_type'(Q16_MIN);
      return angle_type'(v);
   endfunction

   // tanh(s * inv_boundary) in Q1.16, odd-symmetric
   function automatic longint boundary_tanh(angle_type s);
      longint unsigned mag;
      longint unsigned inv;
      longint unsigned x;
      longint unsigned pos;
      longint unsigned idx;
      longint          y;
      longint          a;
      longint          b;
      longint          frac;
      inv = gain_inv_bnd;
      mag = (s < 0) ? -longint'(s) : longint'(s);
      x   = (mag * inv) >> 16;
      if (x >= TANH_X_LIMIT) begin
         y = 65536;
      end else begin
         pos  = x * TANH_POINTS;
         idx  = pos >> TANH_SEG_SH;
         frac = pos & ((64'd1 << TANH_SEG_SH) - 1);
         a    = tanh_lut[idx];
         b    = tanh_lut[idx + 1];
         y    = a + trunc_shift((b - a) * frac, TANH_SEG_SH);
      end
      return (s < 0) ? -y : y;
   endfunction

   // returns 1 when the word changes state or produces a result
   function automatic bit advance_joint_model(opcode_type op, joint_type j,
                                              angle_type tgt, word_type dt);
      longint err;
      longint lam_err;
      longint surf;
      longint reach;
      longint vel;
      longint delta;
      longint lam;
      longint rg;
      longint dtl;
      if (j >= JOINTS) return 1'b0;
      case (op)
         OP_START: begin
            joint_cmd[j] = tgt;
            tracking_on  = 1'b1;
            return 1'b1;
         end
         OP_STOP: begin
            tracking_on = 1'b0;
            return 1'b1;
         end
         OP_STEP: ;
         default: return 1'b0;
      endcase
      if (!tracking_on || dt <= DT_MIN_RAW) return 1'b0;
      lam     = gain_lambda;
      rg      = gain_reach;
      dtl     = dt;
      err     = clamp_q16(longint'(tgt) - longint'(joint_cmd[j]));
      lam_err = clamp_q16(trunc_shift(err * lam, 16));
      surf    = clamp_q16(lam_err - longint'(joint_speed[j]));
      reach   = trunc_shift(rg * boundary_tanh(angle_type'(surf)), 16);
      vel     = clamp_q16(reach + lam_err);
      delta   = trunc_shift(vel * dtl, 24);
      joint_cmd[j]   = clamp_q16(longint'(joint_cmd[j]) + delta);
      joint_speed[j] = angle_type'(vel);
      pending_updates.push_back('{joint: j, angle: joint_cmd[j]});
      return 1'b1;
   endfunction

   task automatic send_item(opcode_type op, joint_type j, angle_type tgt, word_type dt);
      while ($urandom_range(99) < src_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.opcode       <= op;
      req_bus.joint_index  <= j;
      req_bus.target_angle <= tgt;
      req_bus.step_time    <= dt;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (advance_joint_model(op, j, tgt, dt)) applied_items++;
   endtask

   // valid stays high across back-to-back writes; the last one drops it
   task automatic write_register(csr_index_type idx, word_type data, bit last);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (idx)
         CSR_LAMBDA:  gain_lambda  = data;
         CSR_REACH:   gain_reach   = data;
         CSR_INV_BND: gain_inv_bnd = data;
         default: ;
      endcase
      if (last) csr_bus.valid <= 1'b0;
   endtask

   task automatic program_gains(word_type lam, word_type reach, word_type inv);
      write_register(CSR_LAMBDA, lam, 1'b0);
      write_register(CSR_REACH, reach, 1'b0);
      write_register(CSR_INV_BND, inv, 1'b1);
   endtask

   // drain results, then cover a step that may still be running with no word
   task automatic settle_block();
      req_bus.valid <= 1'b0;
      while (pending_updates.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic test_ignored_items();
      send_item(OP_STEP, 3'd0, 32'sd327680, DT_TEN_MS);     // disabled after reset
      send_item(OP_START, 3'd6, 32'sd65536, DT_TEN_MS);     // bad joint: no enable
      send_item(OP_STEP, 3'd0, 32'sd327680, DT_TEN_MS);
      send_item(OP_UNUSED, 3'd0, 32'sd65536, DT_TEN_MS);
      send_item(OP_START, 3'd7, -32'sd65536, DT_ONE_S);
   endtask

   task automatic test_step_basics();
      send_item(OP_START, 3'd0, 32'sd0, 32'd0);
      send_item(OP_STEP, 3'd0, 32'sd655360, DT_TEN_MS);
      send_item(OP_STEP, 3'd0, 32'sd655360, DT_MIN_RAW);     // dt at threshold: ignored
      send_item(OP_STEP, 3'd0, 32'sd655360, DT_MIN_RAW + 1);
      send_item(OP_STEP, 3'd0, 32'sd655360, 32'd0);
      send_item(OP_START, 3'd2, -32'sd6553600, 32'd0);
      send_item(OP_STEP, 3'd2, -32'sd6553600, DT_ONE_S);     // zero error
      send_item(OP_STOP, 3'd7, 32'sd0, 32'd0);              // bad joint: stays enabled
      send_item(OP_STEP, 3'd1, 32'sd65536, DT_ONE_S >> 1);
      send_item(OP_STOP, 3'd3, 32'sd0, 32'd0);
      send_item(OP_STEP, 3'd2, 32'sd65536, DT_ONE_S);
   endtask

   task automatic test_saturation_extremes();
      send_item(OP_START, 3'd5, angle_type'(Q16_MAX), 32'd0);
      send_item(OP_STEP, 3'd5, angle_type'(Q16_MIN), WORD_MAX);
      send_item(OP_STEP, 3'd5, angle_type'(Q16_MAX), WORD_MAX);
      send_item(OP_START, 3'd4, angle_type'(Q16_MIN), WORD_MAX);
      send_item(OP_STEP, 3'd4, angle_type'(Q16_MAX), DT_ONE_S);
   endtask

   task automatic test_register_extremes();
      settle_block();
      write_register(CSR_LAMBDA, WORD_MAX, 1'b0);
      write_register(CSR_REACH, WORD_MAX, 1'b0);
      write_register(CSR_INV_BND, WORD_MAX, 1'b0);
      write_register(CSR_UNUSED, 32'd0, 1'b1);               // must not touch any gain
      send_item(OP_START, 3'd3, 32'sd0, 32'd0);
      send_item(OP_STEP, 3'd3, 32'sd65536, DT_TEN_MS);
      send_item(OP_STEP, 3'd3, -32'sd65536, DT_ONE_S);
      settle_block();
      program_gains(32'd0, 32'd0, 32'd0);
      send_item(OP_STEP, 3'd3, 32'sd3276800, DT_ONE_S);
      send_item(OP_STEP, 3'd1, -32'sd3276800, DT_TEN_MS);
      settle_block();
   endtask

   task automatic test_random_phase(int src_pct, int rsp_pct, word_type lam,
                                    word_type reach, word_type inv, int count);
      int         first;
      int         pick;
      int         dt_pick;
      int         off;
      joint_type  j;
      angle_type  tgt;
      word_type   dt;
      opcode_type op;
      settle_block();
      program_gains(lam, reach, inv);
      src_idle_pct = src_pct;
      rsp_idle_pct = rsp_pct;
      first = applied_items;
      while (applied_items - first < count) begin
         pick = $urandom_range(99);
         j    = $urandom_range(JOINTS - 1);
         off  = $urandom_range(4194304);
         off  = off - 2097152;
         if ($urandom_range(99) < 15) begin
            tgt = $urandom;
         end else begin
            tgt = clamp_q16(longint'(joint_cmd[j]) + off);
         end
         dt_pick = $urandom_range(99);
         if (dt_pick < 10) begin
            dt = $urandom;
         end else if (dt_pick < 15) begin
            dt = $urandom_range(DT_MIN_RAW);
         end else begin
            dt = $urandom_range(2097152, DT_MIN_RAW + 1);
         end
         if (!tracking_on && pick < 70) begin
            op = OP_START;
         end else if (pick < 3) begin
            op = OP_START;
         end else if (pick < 6) begin
            op = OP_STOP;
         end else if (pick < 10) begin
            // noise: any opcode, joints past the end included
            op = opcode_type'($urandom_range(3));
            j  = $urandom_range(7);
         end else begin
            op = OP_STEP;
         end
         send_item(op, j, tgt, dt);
      end
   endtask

   always @(posedge clock) begin
      joint_update_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_updates.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT) begin
                  $display("unexpected result word: joint %0d angle %0d",
                           rsp_bus.joint_index_res, rsp_bus.commanded_angle);
               end
            end else begin
               want = pending_updates.pop_front();
               if (rsp_bus.joint_index_res !== want.joint ||
                   rsp_bus.commanded_angle !== want.angle) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT) begin
                     $display("result mismatch: joint exp %0d got %0d, angle exp %0d got %0d",
                              want.joint, rsp_bus.joint_index_res,
                              want.angle, rsp_bus.commanded_angle);
                  end
               end
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("sliding_mode_joint_tracker_top_tb: FAIL");
         $finish;
      end
   end

   initial begin
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.opcode       <= OP_STEP;
      req_bus.joint_index  <= '0;
      req_bus.target_angle <= '0;
      req_bus.step_time    <= '0;
      csr_bus.valid        <= 1'b0;
      csr_bus.index        <= CSR_LAMBDA;
      csr_bus.data         <= '0;
      gain_lambda  = LAMBDA_RESET;
      gain_reach   = REACH_RESET;
      gain_inv_bnd = INV_BND_RESET;
      for (int i = 0; i < JOINTS; i++) begin
         joint_cmd[i]   = '0;
         joint_speed[i] = '0;
      end
      tracking_on = 1'b0;
      build_tanh_lut();
      src_idle_pct = 27;
      rsp_idle_pct = 49;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_ignored_items();
      test_step_basics();
      test_saturation_extremes();
      test_register_extremes();
      test_random_phase(27, 49, $urandom_range(5 << 16), $urandom_range(200 << 16),
                        $urandom_range(8 << 16, 1 << 12), 160);
      test_random_phase(49, 27, $urandom_range(20 << 16, 1 << 15), $urandom,
                        $urandom_range(64 << 16), 160);
      test_random_phase(0, 0, LAMBDA_RESET, REACH_RESET, INV_BND_RESET, 170);
      settle_block();

      if (fail_count == 0 && pending_updates.size() == 0) begin
         $display("sliding_mode_joint_tracker_top_tb: PASS");
      end else begin
         $display("sliding_mode_joint_tracker_top_tb: FAIL");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/core/smjt_pkg.sv
rtl/core/smjt_ifs.sv
rtl/core/sliding_mode_joint_tracker_top.sv
verif/sliding_mode_joint_tracker_top_tb.sv
